>>> rtl/elh_pkg.sv
// shared types and constants for the event latency histogram
package elh_pkg;

  localparam int CMD_W   = 3;
  localparam int EVNUM_W = 10;
  localparam int DATA_W  = 64;

  localparam logic [CMD_W-1:0] CMD_RECORD  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREEZE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLOSE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

  localparam logic REPORT_SLOT  = 1'b0;
  localparam logic REPORT_CLOSE = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_RECORD,
    ACT_READ,
    ACT_CLOSE
  } act_t;

  typedef struct packed {
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] peak;
  } slot_t;

  typedef struct packed {
    logic clear_en;
    logic capture;
    logic exec;
    act_t act;
    logic was_active;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/elh_item_if.sv
// input item channel
interface elh_item_if;
  import elh_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]   command;
  logic [EVNUM_W-1:0] event_number;
  logic [DATA_W-1:0]  duration;
  logic [DATA_W-1:0]  now_time;

  modport source (output valid, command, event_number, duration, now_time, input ready);
  modport sink (input valid, command, event_number, duration, now_time, output ready);
endinterface

>>> rtl/elh_report_if.sv
// result item channel
interface elh_report_if;
  import elh_pkg::*;

  logic              valid;
  logic              ready;
  logic              report_kind;
  logic              was_active;
  logic [DATA_W-1:0] event_count;
  logic [DATA_W-1:0] time_sum;
  logic [DATA_W-1:0] time_peak;
  logic [DATA_W-1:0] start_stamp;

  modport source (output valid, report_kind, was_active, event_count, time_sum, time_peak,
                  start_stamp, input ready);
  modport sink (input valid, report_kind, was_active, event_count, time_sum, time_peak,
                start_stamp, output ready);
endinterface

>>> rtl/event_latency_histogram.sv
// top level of the event latency histogram with its configuration port
//
// item channel: commands record, freeze, disable, close and read slot, with
//   an event number, a duration and a timestamp; transfer on valid and ready
// report channel: one result per read of a valid slot (count, sum, peak,
//   start stamp) and one per close (grand count and sum, was_active)
// configuration: recording_enable at byte addresses 0-3 (paddr[2] low), to be
//   written over the apb-style port while the block is idle (not enforced);
//   it sets the start mode that the first item after reset latches
// each item has its slot entry read from the single-port slot memory when it is
//   accepted, then in the exec state the updated entry is written back or the
//   report register loaded; no new item is accepted until it leaves exec
// a read or close result is loaded into the report register as its item leaves
//   exec; while a report waits to be taken, the next item is still accepted
//   and only stalls in exec if it has its own result
// reset clears mode, grand totals and start stamp, then sweeps the slot
//   memory to zero one entry a cycle, with item ready low until it is done
module event_latency_histogram #(
  parameter int SLOTS = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  elh_item_if.sink     item,
  elh_report_if.source report
);
  import elh_pkg::*;

  logic       recording_enable;
  logic       reg_sel;
  dp_cmd_t    cmd;
  dp_status_t status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign prdata  = reg_sel ? {31'd0, recording_enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      recording_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      recording_enable <= pwdata[0];
    end
  end

  elh_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .recording_enable (recording_enable),
    .item_valid       (item.valid),
    .item_command     (item.command),
    .item_event_number(item.event_number),
    .item_ready       (item.ready),
    .cmd              (cmd),
    .status           (status)
  );

  elh_datapath #(
    .SLOTS(SLOTS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .item_event_number(item.event_number),
    .item_duration    (item.duration),
    .item_now_time    (item.now_time),
    .cmd              (cmd),
    .status           (status),
    .report           (report)
  );

endmodule

>>> rtl/elh_ctrl.sv
// controller: clearing sweep, mode tracking and per-item sequencing
module elh_ctrl #(
  parameter int SLOTS = 512
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        recording_enable,
  input  logic                        item_valid,
  input  logic [elh_pkg::CMD_W-1:0]   item_command,
  input  logic [elh_pkg::EVNUM_W-1:0] item_event_number,
  output logic                        item_ready,
  output elh_pkg::dp_cmd_t            cmd,
  input  elh_pkg::dp_status_t         status
);
  import elh_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef enum logic [1:0] {
    MODE_OFF,
    MODE_RECORD,
    MODE_FROZEN
  } mode_t;

  state_t state;
  mode_t  mode;
  logic   mode_latched;
  act_t   act;
  logic   was_active;

  mode_t  mode_eff;
  mode_t  mode_next;
  act_t   act_next;
  logic   was_active_next;
  logic   idx_ok;
  logic   accept;
  logic   needs_out;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign idx_ok     = 32'(item_event_number) < SLOTS;
  assign mode_eff   = mode_latched ? mode : (recording_enable ? MODE_RECORD : MODE_OFF);
  assign needs_out  = (act == ACT_READ) || (act == ACT_CLOSE);

  always_comb begin
    mode_next       = mode_eff;
    act_next        = ACT_NONE;
    was_active_next = 1'b1;
    case (item_command)
      CMD_RECORD: begin
        if (mode_eff == MODE_RECORD && idx_ok) act_next = ACT_RECORD;
      end
      CMD_FREEZE: begin
        if (mode_eff == MODE_RECORD) mode_next = MODE_FROZEN;
      end
      CMD_DISABLE: begin
        mode_next = MODE_OFF;
      end
      CMD_CLOSE: begin
        act_next        = ACT_CLOSE;
        was_active_next = (mode_eff != MODE_OFF);
        mode_next       = MODE_OFF;
      end
      CMD_READ: begin
        if (idx_ok) act_next = ACT_READ;
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.clear_en   = (state == ST_CLEAR);
    cmd.capture    = accept;
    cmd.exec       = (state == ST_EXEC) && (!needs_out || status.out_free);
    cmd.act        = act;
    cmd.was_active = was_active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      mode         <= MODE_OFF;
      mode_latched <= 1'b0;
      act          <= ACT_NONE;
      was_active   <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (status.clear_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            mode         <= mode_next;
            mode_latched <= 1'b1;
            act          <= act_next;
            was_active   <= was_active_next;
            state        <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (cmd.exec) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/elh_datapath.sv
// datapath: slot memory, grand totals, start stamp and report register
module elh_datapath #(
  parameter int SLOTS = 512
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [elh_pkg::EVNUM_W-1:0] item_event_number,
  input  logic [elh_pkg::DATA_W-1:0]  item_duration,
  input  logic [elh_pkg::DATA_W-1:0]  item_now_time,
  input  elh_pkg::dp_cmd_t            cmd,
  output elh_pkg::dp_status_t         status,
  elh_report_if.source                report
);
  import elh_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  slot_t             mem [SLOTS];
  slot_t             rd_q;
  slot_t             wr_data;
  slot_t             upd;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     addr_q;
  logic [AW-1:0]     wr_addr;
  logic              wr_en;
  logic [DATA_W-1:0] dur_q;
  logic [DATA_W-1:0] now_q;
  logic [DATA_W-1:0] grand_count;
  logic [DATA_W-1:0] grand_sum;
  logic [DATA_W-1:0] first_stamp;
  logic              do_record;
  logic              do_report;

  assign do_record = cmd.exec && (cmd.act == ACT_RECORD);
  assign do_report = cmd.exec && ((cmd.act == ACT_READ) || (cmd.act == ACT_CLOSE));

  assign upd.count = rd_q.count + 64'd1;
  assign upd.sum   = rd_q.sum + dur_q;
  assign upd.peak  = (dur_q > rd_q.peak) ? dur_q : rd_q.peak;

  assign wr_en   = cmd.clear_en || do_record;
  assign wr_addr = cmd.clear_en ? clr_addr : addr_q;
  assign wr_data = cmd.clear_en ? '0 : upd;

  assign status.clear_last = (clr_addr == AW'(SLOTS - 1));
  assign status.out_free   = !report.valid || report.ready;

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.capture) rd_q <= mem[AW'(item_event_number)];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_q <= AW'(item_event_number);
      dur_q  <= item_duration;
      now_q  <= item_now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      grand_count <= '0;
      grand_sum   <= '0;
      first_stamp <= '0;
    end else begin
      if (cmd.clear_en) clr_addr <= clr_addr + AW'(1);
      if (do_record) begin
        grand_count <= grand_count + 64'd1;
        grand_sum   <= grand_sum + dur_q;
        if (first_stamp == '0) first_stamp <= now_q;
      end
    end
  end

  // report register
  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (do_report) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_report) begin
      report.start_stamp <= first_stamp;
      if (cmd.act == ACT_CLOSE) begin
        report.report_kind <= REPORT_CLOSE;
        report.was_active  <= cmd.was_active;
        report.event_count <= grand_count;
        report.time_sum    <= grand_sum;
        report.time_peak   <= '0;
      end else begin
        report.report_kind <= REPORT_SLOT;
        report.was_active  <= 1'b1;
        report.event_count <= rd_q.count;
        report.time_sum    <= rd_q.sum;
        report.time_peak   <= rd_q.peak;
      end
    end
  end

endmodule

>>> sim/event_latency_histogram_checker.sv
// checker: tracks the statistics table from observed transfers and compares every report
module event_latency_histogram_checker #(
  parameter int SLOTS = 512,
  parameter logic [2:0] ENABLE_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  elh_item_if         items,
  elh_report_if       reports,
  output int          errors,
  output int          outstanding,
  output int          items_seen,
  output int          reports_checked,
  output int          records_taken
);
  import elh_pkg::*;

  typedef enum logic [1:0] {
    MODE_OFF,
    MODE_RECORD,
    MODE_FROZEN
  } mode_e;

  typedef struct packed {
    logic              kind;
    logic              active;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] peak;
    logic [DATA_W-1:0] stamp;
  } report_t;

  mode_e             mode;
  logic              latched;
  logic              start_enable;
  logic [DATA_W-1:0] slot_count [SLOTS];
  logic [DATA_W-1:0] slot_sum [SLOTS];
  logic [DATA_W-1:0] slot_peak [SLOTS];
  logic [DATA_W-1:0] grand_count;
  logic [DATA_W-1:0] total_sum;
  logic [DATA_W-1:0] first_stamp;
  report_t           expected_reports [$];
  int                err_cnt = 0;
  int                item_cnt = 0;
  int                report_cnt = 0;
  int                record_cnt = 0;

  function automatic void apply_item(input logic [CMD_W-1:0] cmd,
                                     input logic [EVNUM_W-1:0] evnum,
                                     input logic [DATA_W-1:0] dur,
                                     input logic [DATA_W-1:0] stamp);
    report_t rep;
    logic    in_range;
    in_range = (int'(evnum) < SLOTS);
    rep = '0;
    if (!latched) begin
      mode = start_enable ? MODE_RECORD : MODE_OFF;
      latched = 1'b1;
    end
    case (cmd)
      CMD_RECORD: begin
        if (mode == MODE_RECORD && in_range) begin
          if (first_stamp == '0) first_stamp = stamp;
          slot_count[evnum] = slot_count[evnum] + 1'b1;
          slot_sum[evnum] = slot_sum[evnum] + dur;
          if (dur > slot_peak[evnum]) slot_peak[evnum] = dur;
          grand_count = grand_count + 1'b1;
          total_sum = total_sum + dur;
          record_cnt++;
        end
      end
      CMD_FREEZE: begin
        if (mode == MODE_RECORD) mode = MODE_FROZEN;
      end
      CMD_DISABLE: mode = MODE_OFF;
      CMD_CLOSE: begin
        rep.kind = REPORT_CLOSE;
        rep.active = (mode != MODE_OFF);
        rep.count = grand_count;
        rep.sum = total_sum;
        rep.peak = '0;
        rep.stamp = first_stamp;
        mode = MODE_OFF;
        expected_reports.push_back(rep);
      end
      CMD_READ: begin
        if (in_range) begin
          rep.kind = REPORT_SLOT;
          rep.active = 1'b1;
          rep.count = slot_count[evnum];
          rep.sum = slot_sum[evnum];
          rep.peak = slot_peak[evnum];
          rep.stamp = first_stamp;
          expected_reports.push_back(rep);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                      input logic [DATA_W-1:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t mismatch in %s: expected %h actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    report_t want;
    if (rst) begin
      mode = MODE_OFF;
      latched = 1'b0;
      start_enable = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_count[i] = '0;
        slot_sum[i] = '0;
        slot_peak[i] = '0;
      end
      grand_count = '0;
      total_sum = '0;
      first_stamp = '0;
      expected_reports.delete();
    end else begin
      if (reports.valid && reports.ready) begin
        report_cnt++;
        if (expected_reports.size() == 0) begin
          err_cnt++;
          $display("%0t unexpected report: kind %0d active %0d count %h sum %h peak %h stamp %h",
                   $time, reports.report_kind, reports.was_active, reports.event_count,
                   reports.time_sum, reports.time_peak, reports.start_stamp);
        end else begin
          want = expected_reports.pop_front();
          check_field("report_kind", DATA_W'(want.kind), DATA_W'(reports.report_kind));
          check_field("was_active", DATA_W'(want.active), DATA_W'(reports.was_active));
          check_field("event_count", want.count, reports.event_count);
          check_field("time_sum", want.sum, reports.time_sum);
          check_field("time_peak", want.peak, reports.time_peak);
          check_field("start_stamp", want.stamp, reports.start_stamp);
        end
      end
      if (items.valid && items.ready) begin
        item_cnt++;
        apply_item(items.command, items.event_number, items.duration, items.now_time);
      end
      if (psel && penable && pwrite && pready && paddr == ENABLE_ADDR) begin
        start_enable = pwdata[0];
      end
    end
    errors <= err_cnt;
    outstanding <= expected_reports.size();
    items_seen <= item_cnt;
    reports_checked <= report_cnt;
    records_taken <= record_cnt;
  end

endmodule

>>> sim/event_latency_histogram_tb.sv
// testbench top: clock, reset, configuration writes and item stimulus for the histogram
module event_latency_histogram_tb;
  import elh_pkg::*;

  localparam int SLOTS = 512;
  localparam logic [2:0] REG_RECORDING_ENABLE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RESERVED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RESERVED_LAST = 3'd7;
  localparam int EVNUM_MAX = 2**EVNUM_W - 1;
  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
  localparam int RECORD_PHASE_ITEMS = 650;
  localparam int FROZEN_PHASE_ITEMS = 150;
  localparam int OFF_PHASE_ITEMS = 250;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  bit          item_calm = 1'b0;
  bit          report_calm = 1'b0;
  int          errors;
  int          outstanding;
  int          items_seen;
  int          reports_checked;
  int          records_taken;

  elh_item_if   item_ch ();
  elh_report_if report_ch ();

  event_latency_histogram #(.SLOTS(SLOTS)) uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .item(item_ch),
    .report(report_ch)
  );

  event_latency_histogram_checker #(
    .SLOTS(SLOTS),
    .ENABLE_ADDR(REG_RECORDING_ENABLE)
  ) stats_check (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .pready(pready),
    .items(item_ch),
    .reports(report_ch),
    .errors(errors),
    .outstanding(outstanding),
    .items_seen(items_seen),
    .reports_checked(reports_checked),
    .records_taken(records_taken)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // mostly a few hot slots at both ends, some anywhere, some out of range
  function automatic logic [EVNUM_W-1:0] pick_slot();
    int r;
    int h;
    r = $urandom_range(0, 9);
    h = $urandom_range(0, 15);
    if (r < 6) return EVNUM_W'((h < 8) ? h : SLOTS - 16 + h);
    if (r < 9) return EVNUM_W'($urandom_range(0, SLOTS - 1));
    return EVNUM_W'($urandom_range(SLOTS, EVNUM_MAX));
  endfunction

  function automatic logic [DATA_W-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return ALL_ONES;
    if (r < 6) return DATA_W'($urandom_range(1, 100000));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [DATA_W-1:0] pick_stamp();
    return ($urandom_range(0, 9) == 0) ? '0 : {$urandom, $urandom};
  endfunction

  function automatic logic [CMD_W-1:0] pick_reserved();
    return CMD_W'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
  endfunction

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [EVNUM_W-1:0] evnum,
                           input logic [DATA_W-1:0] dur, input logic [DATA_W-1:0] stamp);
    int gap;
    if ($urandom_range(0, 47) == 0) item_calm = !item_calm;
    gap = pick_gap(item_calm);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.command <= cmd;
    item_ch.event_number <= evnum;
    item_ch.duration <= dur;
    item_ch.now_time <= stamp;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  always begin : report_sink
    int stall;
    if ($urandom_range(0, 47) == 0) report_calm = !report_calm;
    stall = pick_gap(report_calm);
    if (stall > 0) begin
      report_ch.ready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
    report_ch.ready <= 1'b1;
    @(posedge clk);
    while (!(report_ch.valid && report_ch.ready)) @(posedge clk);
  end

  initial begin
    item_ch.valid <= 1'b0;
    item_ch.command <= CMD_RECORD;
    item_ch.event_number <= '0;
    item_ch.duration <= '0;
    item_ch.now_time <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    cfg_write(REG_RECORDING_ENABLE, 32'd0);
    cfg_write(REG_RECORDING_ENABLE, 32'd1);

    // first item latches record mode; empty slots read back as zero
    send_item(CMD_READ, '0, '0, '0);
    send_item(CMD_READ, EVNUM_W'(SLOTS - 1), '0, '0);
    // zero timestamp leaves the start stamp open
    send_item(CMD_RECORD, '0, '0, '0);
    send_item(CMD_RECORD, '0, ALL_ONES, '0);
    send_item(CMD_RECORD, EVNUM_W'(SLOTS - 1), 64'd1, ALL_ONES);
    send_item(CMD_RECORD, EVNUM_W'(SLOTS - 1), ALL_ONES, 64'd5);
    send_item(CMD_RECORD, EVNUM_W'(SLOTS), 64'd7, 64'd9);
    send_item(CMD_RECORD, EVNUM_W'(EVNUM_MAX), ALL_ONES, ALL_ONES);
    send_item(CMD_READ, '0, '0, '0);
    send_item(CMD_READ, EVNUM_W'(SLOTS - 1), ALL_ONES, ALL_ONES);
    send_item(CMD_READ, EVNUM_W'(SLOTS), '0, '0);
    send_item(CMD_READ, EVNUM_W'(EVNUM_MAX), '0, '0);
    for (int c = CMD_RESERVED_FIRST; c <= CMD_RESERVED_LAST; c++) begin
      send_item(CMD_W'(c), EVNUM_W'(EVNUM_MAX), ALL_ONES, ALL_ONES);
    end

    for (int n = 0; n < RECORD_PHASE_ITEMS; n++) begin
      int r;
      r = $urandom_range(0, 19);
      if (r < 13) send_item(CMD_RECORD, pick_slot(), pick_duration(), pick_stamp());
      else if (r < 18) send_item(CMD_READ, pick_slot(), pick_duration(), pick_stamp());
      else send_item(pick_reserved(), pick_slot(), pick_duration(), pick_stamp());
    end
    drain();
    // enable has no effect once latched
    cfg_write(REG_RECORDING_ENABLE, 32'hFFFF_FFFE);

    send_item(CMD_FREEZE, '0, '0, '0);
    send_item(CMD_RECORD, EVNUM_W'(1), 64'd100, 64'd3);
    send_item(CMD_FREEZE, '0, '0, '0);
    send_item(CMD_READ, EVNUM_W'(1), '0, '0);
    for (int n = 0; n < FROZEN_PHASE_ITEMS; n++) begin
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) send_item(CMD_RECORD, pick_slot(), pick_duration(), pick_stamp());
      else if (r < 7) send_item(CMD_READ, pick_slot(), pick_duration(), pick_stamp());
      else if (r < 8) send_item(CMD_FREEZE, pick_slot(), pick_duration(), pick_stamp());
      else send_item(pick_reserved(), pick_slot(), pick_duration(), pick_stamp());
    end
    // close from frozen, then close again while off
    send_item(CMD_CLOSE, '0, '0, '0);
    send_item(CMD_CLOSE, EVNUM_W'(EVNUM_MAX), ALL_ONES, ALL_ONES);
    send_item(CMD_DISABLE, '0, '0, '0);
    send_item(CMD_RECORD, '0, 64'd50, 64'd2);
    send_item(CMD_FREEZE, '0, '0, '0);
    send_item(CMD_READ, '0, '0, '0);
    drain();
    cfg_write(REG_RECORDING_ENABLE, 32'hFFFF_FFFF);

    for (int n = 0; n < OFF_PHASE_ITEMS; n++) begin
      send_item(CMD_W'($urandom_range(0, 2**CMD_W - 1)), pick_slot(), pick_duration(),
                pick_stamp());
    end
    drain();

    $display("run covered %0d items (%0d records taken) and %0d checked reports",
             items_seen, records_taken, reports_checked);
    $display("phases: record, frozen and off modes, with enable rewritten between phases");
    if (errors == 0 && outstanding == 0) begin
      $display("PASS event_latency_histogram");
    end else begin
      $display("FAIL event_latency_histogram");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("FAIL event_latency_histogram");
    $finish;
  end

endmodule
